// ----- hdl/qts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the quoted token scanner.
// No dependencies; every other file of the block refers to it by scoped names.
package qts_pkg;

  localparam int unsigned KeywordLength = 4;
  localparam int unsigned KwHeld        = KeywordLength - 1;
  localparam int unsigned MaxResults    = 4;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [15:0] CapacityReset = 16'd256;

  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharU     = 8'h55;
  localparam logic [7:0] CharL     = 8'h4C;
  localparam logic [7:0] CharO     = 8'h4F;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CaseBit   = 8'h20;

  typedef enum logic [1:0] {
    PhSkip,
    PhKeyword,
    PhQuote,
    PhWord
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       token_last;
    logic       token_null;
  } out_item_t;

  // Everything one input item produces: kept characters in order, then an
  // optional terminator.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] chars;
    logic [2:0]                 n_chars;
    logic                       term;
    logic                       term_null;
  } burst_t;

  function automatic logic is_space(logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic letter_is(logic [7:0] c, logic [7:0] upper);
    return (c | CaseBit) == (upper | CaseBit);
  endfunction

endpackage

// ----- hdl/qts_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts characters, runs the token phase machine and builds one
// burst of results per item. Depends on qts_pkg.
module qts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qts_pkg::in_item_t in_item_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             full_i,
  output logic             push_o,
  output qts_pkg::burst_t  burst_o
);

  qts_pkg::phase_e phase_q, phase_d;
  logic [qts_pkg::KwHeld-1:0][7:0] kw_buf_q, kw_buf_d;
  logic [1:0]  kw_count_q, kw_count_d;
  logic [15:0] kept_q, kept_d;
  logic [15:0] capacity_q;

  logic        accept;
  logic [7:0]  c;
  logic        eoi;
  logic        nulo;
  logic [15:0] base;
  logic [qts_pkg::MaxResults-1:0]       allow;
  logic [qts_pkg::MaxResults-1:0][7:0]  cand;
  logic [2:0]  n_avail;
  logic [2:0]  n_keep;
  logic        term;
  logic        tnull;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign c          = in_item_i.char_code;
  assign eoi        = in_item_i.end_of_input;

  assign nulo = qts_pkg::letter_is(kw_buf_q[0], qts_pkg::CharN) &&
                qts_pkg::letter_is(kw_buf_q[1], qts_pkg::CharU) &&
                qts_pkg::letter_is(kw_buf_q[2], qts_pkg::CharL) &&
                qts_pkg::letter_is(c, qts_pkg::CharO);

  // A new token starts counting from zero.
  assign base = (phase_q == qts_pkg::PhSkip) ? 16'd0 : kept_q;

  always_comb begin
    for (int j = 0; j < qts_pkg::MaxResults; j++) begin
      allow[j] = ({1'b0, base} + 17'(j + 1)) < {1'b0, capacity_q};
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        qts_pkg::PhSkip: begin
          if (eoi) begin
            phase_d = qts_pkg::PhSkip;
          end else if (qts_pkg::is_space(c)) begin
            phase_d = qts_pkg::PhSkip;
          end else if (qts_pkg::letter_is(c, qts_pkg::CharN)) begin
            phase_d = qts_pkg::PhKeyword;
          end else if (c == qts_pkg::CharQuote) begin
            phase_d = qts_pkg::PhQuote;
          end else begin
            phase_d = qts_pkg::PhWord;
          end
        end
        qts_pkg::PhKeyword: begin
          if (eoi) begin
            phase_d = qts_pkg::PhSkip;
          end else if (kw_count_q < 2'(qts_pkg::KwHeld)) begin
            phase_d = qts_pkg::PhKeyword;
          end else if (nulo) begin
            phase_d = qts_pkg::PhSkip;
          end else begin
            phase_d = qts_pkg::PhWord;
          end
        end
        qts_pkg::PhQuote: begin
          if (eoi || c == qts_pkg::CharQuote) begin
            phase_d = qts_pkg::PhSkip;
          end
        end
        qts_pkg::PhWord: begin
          if (eoi || qts_pkg::is_space(c)) begin
            phase_d = qts_pkg::PhSkip;
          end
        end
        default: phase_d = qts_pkg::PhSkip;
      endcase
    end
  end

  // Outputs and data state
  always_comb begin
    cand       = '0;
    n_avail    = 3'd0;
    term       = 1'b0;
    tnull      = 1'b0;
    kw_buf_d   = kw_buf_q;
    kw_count_d = kw_count_q;
    if (accept) begin
      case (phase_q)
        qts_pkg::PhSkip: begin
          if (eoi) begin
            term = 1'b1;
          end else if (qts_pkg::is_space(c)) begin
            term = 1'b0;
          end else if (qts_pkg::letter_is(c, qts_pkg::CharN)) begin
            kw_buf_d[0] = c;
            kw_count_d  = 2'd1;
          end else if (c != qts_pkg::CharQuote) begin
            cand[0] = c;
            n_avail = 3'd1;
          end
        end
        qts_pkg::PhKeyword: begin
          if (eoi) begin
            cand[qts_pkg::KwHeld-1:0] = kw_buf_q;
            n_avail    = {1'b0, kw_count_q};
            term       = 1'b1;
            kw_count_d = 2'd0;
          end else if (kw_count_q < 2'(qts_pkg::KwHeld)) begin
            kw_buf_d[kw_count_q] = c;
            kw_count_d           = kw_count_q + 2'd1;
          end else if (nulo) begin
            term       = 1'b1;
            tnull      = 1'b1;
            kw_count_d = 2'd0;
          end else begin
            cand       = {c, kw_buf_q};
            n_avail    = 3'(qts_pkg::MaxResults);
            kw_count_d = 2'd0;
          end
        end
        qts_pkg::PhQuote: begin
          if (eoi || c == qts_pkg::CharQuote) begin
            term = 1'b1;
          end else begin
            cand[0] = c;
            n_avail = 3'd1;
          end
        end
        qts_pkg::PhWord: begin
          if (eoi || qts_pkg::is_space(c)) begin
            term = 1'b1;
          end else begin
            cand[0] = c;
            n_avail = 3'd1;
          end
        end
        default: term = 1'b0;
      endcase
    end
  end

  // Capacity allowance falls off monotonically, so the kept characters are a prefix.
  always_comb begin
    n_keep = 3'd0;
    for (int j = 0; j < qts_pkg::MaxResults; j++) begin
      if (3'(j) < n_avail && allow[j]) begin
        n_keep = 3'(j + 1);
      end
    end
  end

  always_comb begin
    kept_d = kept_q;
    if (accept) begin
      kept_d = term ? 16'd0 : base + {13'd0, n_keep};
    end
  end

  assign push_o            = accept && (n_keep != 3'd0 || term);
  assign burst_o.chars     = cand;
  assign burst_o.n_chars   = n_keep;
  assign burst_o.term      = term;
  assign burst_o.term_null = tnull;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= qts_pkg::PhSkip;
      kw_count_q <= 2'd0;
      kept_q     <= 16'd0;
      capacity_q <= qts_pkg::CapacityReset;
    end else begin
      phase_q    <= phase_d;
      kw_count_q <= kw_count_d;
      kept_q     <= kept_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kw_buf_q <= kw_buf_d;
  end

  a_kw_count_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == qts_pkg::PhKeyword) == (kw_count_q != 2'd0))
    else $error("keyword count out of step with phase");

  a_term_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && burst_o.term |=> phase_q == qts_pkg::PhSkip && kept_q == 16'd0)
    else $error("terminator did not return to skipping");

  a_burst_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (4'(burst_o.n_chars) + 4'(burst_o.term)) <= 4'(qts_pkg::MaxResults))
    else $error("burst larger than the result limit");

endmodule

// ----- hdl/qts_queue.sv -----
`timescale 1ns / 1ps
// Short queue of result bursts between front and back end.
// Depends on qts_pkg for the burst type.
module qts_queue #(
  parameter int unsigned Depth = qts_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qts_pkg::burst_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output qts_pkg::burst_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  qts_pkg::burst_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = count_q == CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("burst pushed into a full queue");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with pointers apart");

endmodule

// ----- hdl/qts_back.sv -----
`timescale 1ns / 1ps
// Back end: serialises the head burst into single results through an output
// register. Depends on qts_pkg.
module qts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  qts_pkg::burst_t    head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qts_pkg::out_item_t out_item_o
);

  logic [1:0]         pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  qts_pkg::out_item_t out_q;
  qts_pkg::out_item_t slot;
  logic [2:0]         total;
  logic               last;
  logic               load;

  // Characters come first, the terminator after them.
  always_comb begin
    if ({1'b0, pos_q} < head_i.n_chars) begin
      slot.out_char   = head_i.chars[pos_q];
      slot.has_char   = 1'b1;
      slot.token_last = 1'b0;
      slot.token_null = 1'b0;
    end else begin
      slot.out_char   = 8'd0;
      slot.has_char   = 1'b0;
      slot.token_last = 1'b1;
      slot.token_null = head_i.term_null;
    end
  end

  assign total = head_i.n_chars + {2'd0, head_i.term};
  assign last  = ({1'b0, pos_q} + 3'd1) == total;
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = last ? 2'd0 : pos_q + 2'd1;
    end
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_pos_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd0 |-> head_valid_i)
    else $error("serialiser mid-burst without a burst");

  a_burst_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (head_i.n_chars != 3'd0 || head_i.term))
    else $error("empty burst at queue head");

  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> pos_q == 2'd0)
    else $error("position not rewound after burst");

endmodule

// ----- hdl/quoted_token_scanner_top.sv -----
`timescale 1ns / 1ps
// Quoted token scanner: one character per transfer in, token characters and
// terminators out. The first result of an item is written into the burst queue and
// then loaded into the output register. One item is taken per cycle; an item with k
// results (at most 4) occupies the single output register one result at a time,
// buffered by the burst queue, and input stalls only while all queue entries are taken.
// Reset: phase returns to skipping, capacity to 256, queue and output empty.
module quoted_token_scanner_top #(
  parameter int unsigned QueueDepth = qts_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qts_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  qts_pkg::burst_t push_data;
  qts_pkg::burst_t head;

  qts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .burst_o     (push_data)
  );

  qts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  qts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
